@@ rtl/k_way_timestamp_merge_top_assert.svh @@
// Assertion macros for the k-way timestamp merge top level.
// No dependencies; included by k_way_timestamp_merge_top.sv.
`ifndef K_WAY_TIMESTAMP_MERGE_TOP_ASSERT_SVH
`define K_WAY_TIMESTAMP_MERGE_TOP_ASSERT_SVH

// property must hold at every clock edge out of reset
`define KTM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true out of reset
`define KTM_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ rtl/ktm_pkg.sv @@
// Shared types, constants and compare function for the k-way timestamp merge.
// No dependencies.
`timescale 1ns / 1ps

package ktm_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int DATE_BITS   = 32;
    localparam int TIME_BITS   = 32;
    localparam int SRC_W       = 4;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    localparam int TREE_LEVELS = $clog2(MAX_SOURCES);
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;
    localparam int LVL_CNT_W   = $clog2(TREE_LEVELS + 1);

    localparam int S_DATA_W = ((SRC_W + DATE_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((SRC_W + DATE_BITS + TIME_BITS + 7) / 8) * 8;

    localparam logic CMD_OFFER   = 1'b0;
    localparam logic CMD_EXHAUST = 1'b1;

    typedef struct packed {
        logic                 vld;
        logic [SRC_W-1:0]     idx;
        logic [DATE_BITS-1:0] date;
        logic [TIME_BITS-1:0] tkey;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETTLE
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic any_waiting;
        logic out_free;
    } status_t;

    // smaller of two heads; ties and invalid right side keep the left one
    function automatic node_t min_node(input node_t a, input node_t b);
        node_t r;
        r = a;
        if (b.vld && (!a.vld || ({b.date, b.tkey} < {a.date, a.tkey}))) begin
            r = b;
        end
        return r;
    endfunction

endpackage

@@ rtl/ktm_min_tree.sv @@
// Registered binary minimum tree over the stored source heads.
// Depends on ktm_pkg.
`timescale 1ns / 1ps

module ktm_min_tree (
    input  logic           aclk,
    input  ktm_pkg::node_t leaf_in [ktm_pkg::MAX_SOURCES],
    output ktm_pkg::node_t root_out
);
    import ktm_pkg::*;

    node_t node_reg  [1:TREE_LEAVES-1];
    node_t node_next [1:TREE_LEAVES-1];
    node_t node_w    [1:2*TREE_LEAVES-1];

    genvar k;
    generate
        for (k = 0; k < TREE_LEAVES; k++) begin : g_leaf
            if (k < MAX_SOURCES) begin : g_used
                assign node_w[TREE_LEAVES+k] = leaf_in[k];
            end else begin : g_pad
                assign node_w[TREE_LEAVES+k] = '0;
            end
        end
        for (k = 1; k < TREE_LEAVES; k++) begin : g_node
            assign node_w[k]    = node_reg[k];
            assign node_next[k] = min_node(node_w[2*k], node_w[2*k+1]);
            always_ff @(posedge aclk) begin
                node_reg[k] <= node_next[k];
            end
        end
    endgenerate

    assign root_out = node_reg[1];

endmodule

@@ rtl/ktm_datapath.sv @@
// Datapath: head store, refill flags, min tree, config and output registers.
// Depends on ktm_pkg and ktm_min_tree.
`timescale 1ns / 1ps

module ktm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ktm_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [ktm_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ktm_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    input  ktm_pkg::cmd_t                 cmd,
    output ktm_pkg::status_t              sts
);
    import ktm_pkg::*;

    logic [CFG_W-1:0]     cfg_reg;
    logic [DATE_BITS-1:0] head_date_reg [MAX_SOURCES];
    logic [TIME_BITS-1:0] head_time_reg [MAX_SOURCES];
    logic [MAX_SOURCES-1:0] valid_reg, valid_next;
    logic [MAX_SOURCES-1:0] awaiting_reg, awaiting_next;
    logic [MAX_SOURCES-1:0] active;
    logic [MAX_SOURCES-1:0] take;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [SRC_W-1:0]     m_src_reg;
    logic [DATE_BITS-1:0] m_date_reg;
    logic [TIME_BITS-1:0] m_time_reg;
    logic                 m_done_reg;

    logic [SRC_W-1:0]     in_src;
    logic [DATE_BITS-1:0] in_date;
    logic [TIME_BITS-1:0] in_time;

    node_t leaf [MAX_SOURCES];
    node_t root;

    assign in_src  = s_tdata[SRC_W-1:0];
    assign in_date = s_tdata[SRC_W +: DATE_BITS];
    assign in_time = s_tdata[SRC_W+DATE_BITS +: TIME_BITS];

    // register 0 counts as one source
    always_comb begin
        for (int i = 0; i < MAX_SOURCES; i++) begin
            active[i] = (i < int'(cfg_reg)) || (i == 0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SOURCES; g++) begin : g_leaf
            assign leaf[g].vld  = valid_reg[g] && active[g];
            assign leaf[g].idx  = SRC_W'(g);
            assign leaf[g].date = head_date_reg[g];
            assign leaf[g].tkey = head_time_reg[g];

            assign take[g] = cmd.load && (in_src == SRC_W'(g)) && active[g]
                             && awaiting_reg[g];

            always_ff @(posedge aclk) begin
                if (take[g] && (s_tuser == CMD_OFFER)) begin
                    head_date_reg[g] <= in_date;
                    head_time_reg[g] <= in_time;
                end
            end
        end
    endgenerate

    ktm_min_tree u_tree (
        .aclk     (aclk),
        .leaf_in  (leaf),
        .root_out (root)
    );

    always_comb begin
        valid_next    = valid_reg;
        awaiting_next = awaiting_reg;
        for (int i = 0; i < MAX_SOURCES; i++) begin
            if (take[i]) begin
                awaiting_next[i] = 1'b0;
                valid_next[i]    = (s_tuser == CMD_OFFER);
            end
        end
        if (cmd.emit) begin
            if (root.vld) begin
                for (int i = 0; i < MAX_SOURCES; i++) begin
                    if (root.idx == SRC_W'(i)) begin
                        valid_next[i]    = 1'b0;
                        awaiting_next[i] = 1'b1;
                    end
                end
            end else begin
                // all sources exhausted: rearm
                valid_next    = '0;
                awaiting_next = '1;
            end
        end
    end

    assign m_tvalid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= ACTIVE_RESET;
            valid_reg    <= '0;
            awaiting_reg <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            valid_reg    <= valid_next;
            awaiting_reg <= awaiting_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (root.vld) begin
                m_src_reg  <= root.idx;
                m_date_reg <= root.date;
                m_time_reg <= root.tkey;
                m_done_reg <= 1'b0;
            end else begin
                m_src_reg  <= '0;
                m_date_reg <= '0;
                m_time_reg <= '0;
                m_done_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_time_reg, m_date_reg, m_src_reg});
    assign m_tuser  = m_done_reg;

    assign sts.any_waiting = |(awaiting_reg & active);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

endmodule

@@ rtl/ktm_ctrl.sv @@
// Controller: accepts a transaction, checks refill state, waits out the tree.
// Depends on ktm_pkg.
`timescale 1ns / 1ps

module ktm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ktm_pkg::status_t sts,
    output ktm_pkg::cmd_t    cmd
);
    import ktm_pkg::*;

    state_t                 state_reg, state_next;
    logic [LVL_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.any_waiting) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next   = LVL_CNT_W'(1);
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                // root is current once every tree level has captured the new state
                if (cnt_reg == LVL_CNT_W'(TREE_LEVELS)) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg + LVL_CNT_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/k_way_timestamp_merge_top.sv @@
// K-way timestamp merge, top level: controller plus datapath, assertions.
// Depends on ktm_pkg, ktm_ctrl, ktm_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "k_way_timestamp_merge_top_assert.svh"

// Merges up to 16 sorted record streams by (date, time), ties to the lower
// source index. Each input transaction either offers a source's next head
// (s_tuser = 0) or marks that source exhausted (s_tuser = 1). Once no active
// source awaits a refill, the smallest head goes out and that source must be
// refilled next; when all are exhausted a done marker (m_tuser = 1, zero
// data) goes out and the block rearms. A transaction that causes no result
// passes through the accept and check states only; one that causes a result
// also waits out the four registered levels of the minimum tree before the
// next input is taken. A result waiting in the output register does not
// block the next input unless a new result must be loaded.
module k_way_timestamp_merge_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ktm_pkg::CFG_W-1:0]     cfg_wr_data,  // active_sources
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ktm_pkg::S_DATA_W-1:0]  s_tdata,      // source, date, time_req
    input  logic                          s_tuser,      // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ktm_pkg::M_DATA_W-1:0]  m_tdata,      // out_source, out_date, out_time
    output logic                          m_tuser       // done_res
);
    import ktm_pkg::*;

    cmd_t    cmd;
    status_t sts;

    ktm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ktm_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

    `KTM_ASSERT_CLK(a_emit_out_free, aclk, aresetn, cmd.emit |-> sts.out_free, "emit into busy output")
    `KTM_ASSERT_NEVER(a_load_and_emit, aclk, aresetn, cmd.load && cmd.emit, "load and emit together")
    `KTM_ASSERT_CLK(a_valid_from_emit, aclk, aresetn, $rose(m_tvalid) |-> $past(cmd.emit), "result without emit")

endmodule
